// File: rtl/core/slt_pkg.sv
// shared types and constants for the sorted leaf table
// no dependencies; used by the interfaces, the probe unit and the top level
package slt_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int REQ_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PROBE,
        ST_DECIDE,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    // flags from the shared probe unit
    typedef struct packed {
        logic empty;   // search range lo..hi-1 is empty (lo equals hi)
        logic eq;      // search key equals probed key
        logic lt;      // search key below probed key
    } probe_res_t;

endpackage

// File: rtl/core/slt_if.sv
// request and response channel interfaces for the sorted leaf table
// depends on slt_pkg for field widths
interface slt_req_if;
    logic                         valid;
    logic                         ready;
    logic [slt_pkg::REQ_W-1:0]    req_type;
    logic [slt_pkg::KEY_W-1:0]    key;
    logic [slt_pkg::VAL_W-1:0]    value_in;

    modport source (output valid, output req_type, output key, output value_in,
                    input ready);
    modport sink   (input valid, input req_type, input key, input value_in,
                    output ready);
endinterface

interface slt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [slt_pkg::POS_W-1:0]    position;
    logic [slt_pkg::POS_W-1:0]    entry_count;
    logic                         full_refused;
    logic [slt_pkg::VAL_W-1:0]    value_out;

    modport source (output valid, output found, output position, output entry_count,
                    output full_refused, output value_out, input ready);
    modport sink   (input valid, input found, input position, input entry_count,
                    input full_refused, input value_out, output ready);
endinterface

// File: rtl/core/slt_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module slt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/slt_probe.sv
// shared binary search unit: midpoint of the range and key compare
// depends on slt_pkg for the result flags
module slt_probe #(
    parameter int CW = 5
) (
    input  logic [CW-1:0]                lo,
    input  logic [CW-1:0]                hi,
    input  logic [slt_pkg::KEY_W-1:0]    key,
    input  logic [slt_pkg::KEY_W-1:0]    probe_key,
    output logic [CW-1:0]                mid,
    output slt_pkg::probe_res_t          res
);

    logic [CW:0] sum;

    assign sum       = {1'b0, lo} + {1'b0, hi};
    assign mid       = sum[CW:1];
    assign res.empty = (lo == hi);
    assign res.eq    = (key == probe_key);
    assign res.lt    = (key < probe_key);

endmodule

// File: rtl/core/sorted_leaf_table_search_insert.sv
// sorted leaf table: binary search find, ordered insert and clear
// depends on slt_pkg, slt_if, slt_ram and slt_probe
//
// usage: one request word enters on req (req_type, key, value_in) and one
// response word leaves on rsp (found, position, entry_count, full_refused,
// value_out) for every request. keys are held in ascending unsigned order in
// one memory of MAX_ENTRIES rows, each row a key with its payload.
// a find is a binary search, one probe of the shared compare unit at a time.
// an insert then moves the rows from the found position upward, one row per
// cycle through the memory's single write port, and writes the new row last.
// clear and reserved codes go straight to the response. req is ready only
// while the sequencer is idle. the response sits in an output register; the
// next request is taken while it waits, and that request's work stalls at
// its end until rsp drains. reset empties the table at once (entry count
// zero); memory contents are left as they are and rows above the count are
// never read.
module sorted_leaf_table_search_insert #(
    parameter int MAX_ENTRIES   = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    slt_req_if.sink     req,
    slt_rsp_if.source   rsp
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int SW = (PAYLOAD_WIDTH < slt_pkg::VAL_W) ? PAYLOAD_WIDTH : slt_pkg::VAL_W;
    localparam int RW = slt_pkg::KEY_W + SW;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

    slt_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 lo_reg, lo_next;
    logic [CW-1:0]                 hi_reg, hi_next;
    logic [CW-1:0]                 mid_reg, mid_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 pos_reg, pos_next;
    logic                          pend_reg, pend_next;
    logic [AW-1:0]                 wr_addr_reg, wr_addr_next;
    logic [slt_pkg::REQ_W-1:0]     kind_reg, kind_next;
    logic [slt_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [SW-1:0]                 val_reg, val_next;
    logic                          hit_reg, hit_next;
    logic [SW-1:0]                 vout_reg, vout_next;
    logic                          refused_reg, refused_next;

    logic                          rsp_valid_reg;
    logic                          rsp_found_reg;
    logic [slt_pkg::POS_W-1:0]     rsp_pos_reg;
    logic [slt_pkg::POS_W-1:0]     rsp_count_reg;
    logic                          rsp_refused_reg;
    logic [slt_pkg::VAL_W-1:0]     rsp_value_reg;
    logic                          out_load;

    logic                          ram_we;
    logic [AW-1:0]                 ram_wa;
    logic [RW-1:0]                 ram_wd;
    logic                          ram_re;
    logic [AW-1:0]                 ram_ra;
    logic [RW-1:0]                 ram_rd;

    logic [CW-1:0]                 pr_mid;
    slt_pkg::probe_res_t           pr_res;
    logic [CW-1:0]                 idx_m1;

    assign idx_m1 = idx_reg - 1'b1;

    slt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    slt_probe #(
        .CW (CW)
    ) u_probe (
        .lo        (lo_reg),
        .hi        (hi_reg),
        .key       (key_reg),
        .probe_key (ram_rd[RW-1:SW]),
        .mid       (pr_mid),
        .res       (pr_res)
    );

    assign req.ready = (state_reg == slt_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slt_pkg::ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        wr_addr_reg <= wr_addr_next;
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        hit_reg     <= hit_next;
        vout_reg    <= vout_next;
        refused_reg <= refused_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        pend_next    = pend_reg;
        wr_addr_next = wr_addr_reg;
        kind_next    = kind_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        hit_next     = hit_reg;
        vout_next    = vout_reg;
        refused_next = refused_reg;
        ram_we       = 1'b0;
        ram_wa       = '0;
        ram_wd       = {key_reg, val_reg};
        ram_re       = 1'b0;
        ram_ra       = '0;
        out_load     = 1'b0;

        case (state_reg)
            slt_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next    = req.req_type;
                    key_next     = req.key;
                    val_next     = req.value_in[SW-1:0];
                    hit_next     = 1'b0;
                    pos_next     = '0;
                    vout_next    = '0;
                    refused_next = 1'b0;
                    lo_next      = '0;
                    hi_next      = count_reg;
                    pend_next    = 1'b0;
                    case (req.req_type)
                        slt_pkg::REQ_FIND,
                        slt_pkg::REQ_INSERT:
                        begin
                            state_next = slt_pkg::ST_SEARCH;
                        end
                        slt_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = slt_pkg::ST_FINISH;
                        end
                        default:
                        begin
                            state_next = slt_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            slt_pkg::ST_SEARCH:
            begin
                if (pr_res.empty)
                begin
                    pos_next   = lo_reg;
                    state_next = slt_pkg::ST_DECIDE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_ra     = pr_mid[AW-1:0];
                    mid_next   = pr_mid;
                    state_next = slt_pkg::ST_PROBE;
                end
            end

            slt_pkg::ST_PROBE:
            begin
                if (pr_res.eq)
                begin
                    hit_next   = 1'b1;
                    pos_next   = mid_reg;
                    vout_next  = ram_rd[SW-1:0];
                    state_next = slt_pkg::ST_DECIDE;
                end
                else
                begin
                    if (pr_res.lt)
                    begin
                        hi_next = mid_reg;
                    end
                    else
                    begin
                        lo_next = mid_reg + 1'b1;
                    end
                    state_next = slt_pkg::ST_SEARCH;
                end
            end

            slt_pkg::ST_DECIDE:
            begin
                if (kind_reg == slt_pkg::REQ_INSERT)
                begin
                    if (count_reg >= MAX_COUNT || pos_reg > count_reg)
                    begin
                        refused_next = 1'b1;
                        state_next   = slt_pkg::ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        pend_next  = 1'b0;
                        state_next = slt_pkg::ST_SHIFT;
                    end
                end
                else
                begin
                    state_next = slt_pkg::ST_FINISH;
                end
            end

            slt_pkg::ST_SHIFT:
            begin
                // row read last cycle is written one place up
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                    ram_wa = wr_addr_reg;
                    ram_wd = ram_rd;
                end
                if (idx_reg > pos_reg)
                begin
                    ram_re       = 1'b1;
                    ram_ra       = idx_m1[AW-1:0];
                    wr_addr_next = idx_reg[AW-1:0];
                    idx_next     = idx_m1;
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_wa     = pos_reg[AW-1:0];
                        ram_wd     = {key_reg, val_reg};
                        count_next = count_reg + 1'b1;
                        state_next = slt_pkg::ST_FINISH;
                    end
                end
            end

            slt_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = slt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = slt_pkg::ST_IDLE;
            end
        endcase
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_found_reg   <= hit_reg;
            rsp_pos_reg     <= slt_pkg::POS_W'(pos_reg);
            rsp_count_reg   <= slt_pkg::POS_W'(count_reg);
            rsp_refused_reg <= refused_reg;
            rsp_value_reg   <= slt_pkg::VAL_W'(vout_reg);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.found        = rsp_found_reg;
    assign rsp.position     = rsp_pos_reg;
    assign rsp.entry_count  = rsp_count_reg;
    assign rsp.full_refused = rsp_refused_reg;
    assign rsp.value_out    = rsp_value_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("entry count above table size");

    a_write_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == slt_pkg::ST_SHIFT))
        else $error("memory written outside the shift phase");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slt_pkg::ST_PROBE) |-> (mid_reg < hi_reg && mid_reg >= lo_reg))
        else $error("probe index outside search range");

    a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> rsp.valid)
        else $error("response not presented after load");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slt_pkg::ST_SHIFT && state_next == slt_pkg::ST_FINISH)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the table by one");
`endif

endmodule

// File: bench/leaf_table_compare.sv
// response checker for the sorted leaf table: watches both channels, keeps its own table
// and compares every response word with the predicted one; depends on slt_pkg and slt_if
module leaf_table_compare
    import slt_pkg::*;
#(
    parameter int MAX_ENTRIES   = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    slt_req_if   req,
    slt_rsp_if   rsp,
    output int   mismatches,
    output int   pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] entry_count;
        logic             full_refused;
        logic [VAL_W-1:0] value_out;
    } leaf_result_t;

    localparam logic [VAL_W-1:0] PAY_MASK =
        (PAYLOAD_WIDTH >= VAL_W) ? {VAL_W{1'b1}} : ((VAL_W'(1) << PAYLOAD_WIDTH) - 1);

    logic [KEY_W-1:0] shadow_keys [MAX_ENTRIES];
    logic [VAL_W-1:0] shadow_vals [MAX_ENTRIES];
    int               shadow_fill = 0;

    leaf_result_t     expected_q [$];
    int               fail_n = 0;
    int               wait_n = 0;

    assign mismatches = fail_n;
    assign pending    = wait_n;

    // search the sorted shadow table, then apply the request to it
    function automatic leaf_result_t leaf_apply(input logic [REQ_W-1:0] op,
                                                input logic [KEY_W-1:0] k,
                                                input logic [VAL_W-1:0] v);
        leaf_result_t r;
        int           lo;
        int           hi;
        int           mid;
        bit           hit;
        r   = '0;
        lo  = 0;
        hit = 1'b0;
        if (op == REQ_FIND || op == REQ_INSERT)
        begin
            hi = (shadow_fill > MAX_ENTRIES) ? MAX_ENTRIES : shadow_fill;
            while (lo != hi && !hit)
            begin
                mid = (lo + hi) / 2;
                if (k == shadow_keys[mid])
                begin
                    hit = 1'b1;
                    lo  = mid;
                end
                else if (k < shadow_keys[mid])
                    hi = mid;
                else
                    lo = mid + 1;
            end
            r.found    = hit;
            r.position = POS_W'(lo);
            if (hit)
                r.value_out = shadow_vals[lo];
            if (op == REQ_INSERT)
            begin
                if (shadow_fill >= MAX_ENTRIES || lo > shadow_fill)
                    r.full_refused = 1'b1;
                else
                begin
                    // duplicates land in front of the equal key that was met
                    for (int i = shadow_fill; i > lo; i--)
                    begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_vals[i] = shadow_vals[i-1];
                    end
                    shadow_keys[lo] = k;
                    shadow_vals[lo] = v & PAY_MASK;
                    shadow_fill++;
                end
            end
        end
        else if (op == REQ_CLEAR)
            shadow_fill = 0;
        r.entry_count = POS_W'(shadow_fill);
        return r;
    endfunction

    always @(posedge clk)
    begin
        leaf_result_t got;
        leaf_result_t want;
        if (rst_n)
        begin
            // response first: it always belongs to an older request word
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.found, rsp.position, rsp.entry_count, rsp.full_refused,
                        rsp.value_out};
                if (expected_q.size() == 0)
                begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("unexpected response word: found=%0d pos=%0d count=%0d refused=%0d value=%h",
                                 got.found, got.position, got.entry_count, got.full_refused,
                                 got.value_out);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        fail_n++;
                        if (fail_n <= 10)
                        begin
                            $display("mismatch at %0t: expected found=%0d pos=%0d count=%0d refused=%0d value=%h",
                                     $realtime, want.found, want.position, want.entry_count,
                                     want.full_refused, want.value_out);
                            $display("                  got found=%0d pos=%0d count=%0d refused=%0d value=%h",
                                     got.found, got.position, got.entry_count,
                                     got.full_refused, got.value_out);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(leaf_apply(req.req_type, req.key, req.value_in));
            wait_n = expected_q.size();
        end
    end

endmodule

// File: bench/sorted_leaf_table_search_insert_tb.sv
// top of the sorted leaf table bench: clock, reset, request and response pacing, verdict
// depends on slt_pkg, slt_if, the block and leaf_table_compare
module sorted_leaf_table_search_insert_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam int               TABLE_DEPTH  = 16;
    localparam int               RANDOM_WORDS = 1700;
    localparam int               STALL_LIMIT  = 5000;
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    logic clk;
    logic rst_n;

    slt_req_if req_ch ();
    slt_rsp_if rsp_ch ();

    int               mismatches;
    int               pending;
    bit               no_gaps = 1'b0;
    logic [KEY_W-1:0] seen_keys [TABLE_DEPTH];
    int               seen_wr = 0;

    sorted_leaf_table_search_insert #(
        .MAX_ENTRIES   (TABLE_DEPTH),
        .PAYLOAD_WIDTH (VAL_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    leaf_table_compare #(
        .MAX_ENTRIES   (TABLE_DEPTH),
        .PAYLOAD_WIDTH (VAL_W)
    ) u_compare (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // offer one request word after a random gap and hold it until taken
    task automatic offer_word(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
        int gap;
        int sel;
        sel = $urandom_range(0, 99);
        if (no_gaps || sel < 55)
            gap = 0;
        else if (sel < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(5, 30);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.key      <= k;
        req_ch.value_in <= v;
        if (op == REQ_INSERT)
        begin
            seen_keys[seen_wr] = k;
            seen_wr = (seen_wr + 1) % TABLE_DEPTH;
        end
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    initial
    begin
        int               sel;
        int               key_pick;
        logic [REQ_W-1:0] op;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        for (int i = 0; i < TABLE_DEPTH; i++)
            seen_keys[i] = '0;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_FIND;
        req_ch.key      <= '0;
        req_ch.value_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, key extremes, duplicate, reserved code, full, clear
        offer_word(REQ_FIND,     32'h0000_0000, 32'h0000_0000);
        offer_word(REQ_INSERT,   32'hFFFF_FFFF, 32'h0000_0000);
        offer_word(REQ_INSERT,   32'h0000_0000, 32'hFFFF_FFFF);
        offer_word(REQ_INSERT,   32'h0000_0000, 32'h5A5A_5A5A);
        offer_word(REQ_FIND,     32'h0000_0000, 32'h0000_0000);
        offer_word(REQ_FIND,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_word(REQ_FIND,     32'h8000_0000, 32'h0000_0000);
        offer_word(REQ_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 1; i <= 13; i++)
            offer_word(REQ_INSERT, 32'h1000_0000 * i + i, 32'hA500_0000 + i);
        offer_word(REQ_INSERT,   32'h1234_5678, 32'hDEAD_BEEF);
        offer_word(REQ_FIND,     32'h0000_0000, 32'h0000_0000);
        offer_word(REQ_CLEAR,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_word(REQ_FIND,     32'hFFFF_FFFF, 32'h0000_0000);

        // random: mostly inserts and finds between rare clears so the table fills often
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 150 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 3)
                op = REQ_CLEAR;
            else if (sel < 6)
                op = REQ_RESERVED;
            else if (sel < 52)
                op = REQ_INSERT;
            else
                op = REQ_FIND;
            key_pick = $urandom_range(0, 9);
            if (key_pick < 3)
                k = KEY_W'($urandom_range(0, 15));
            else if (key_pick < 5)
                k = seen_keys[$urandom_range(0, TABLE_DEPTH - 1)];
            else if (key_pick == 5)
                k = ($urandom_range(0, 1) == 0) ? '0 : 32'hFFFF_FFFF - $urandom_range(0, 7);
            else
                k = $urandom;
            // finds mostly look for keys that were put in
            if (op == REQ_FIND && $urandom_range(0, 1) == 0)
                k = seen_keys[$urandom_range(0, TABLE_DEPTH - 1)];
            if ($urandom_range(0, 7) == 0)
                v = ($urandom_range(0, 1) == 0) ? '0 : '1;
            else
                v = $urandom;
            offer_word(op, k, v);
        end
        req_ch.valid <= 1'b0;

        // let the checker count the last accepted word before polling
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // response side pacing, with one long hold-off so requests back up
    initial
    begin
        int sel;
        int hold;
        int blocks;
        blocks = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            blocks++;
            if (blocks == 40)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            sel = $urandom_range(0, 99);
            if (sel < 45)
                hold = 0;
            else if (sel < 85)
                hold = $urandom_range(1, 3);
            else
                hold = $urandom_range(8, 40);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            hold = ($urandom_range(0, 99) < 5) ? 200 : $urandom_range(1, 20);
            repeat (hold) @(posedge clk);
        end
    end

    // watchdog on cycles where no word moves on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/slt_pkg.sv
rtl/core/slt_if.sv
rtl/core/slt_ram.sv
rtl/core/slt_probe.sv
rtl/core/sorted_leaf_table_search_insert.sv
bench/leaf_table_compare.sv
bench/sorted_leaf_table_search_insert_tb.sv
